/* hw/rtl/qlps_pkg.sv */
// ----------------------------------------------------------------------------
// qlps_pkg
// Shared types and constants of the Q-learning parent selector.
// ----------------------------------------------------------------------------
`default_nettype none

package qlps_pkg;

  localparam int TAU_CAP     = 1000;
  localparam int Q_LIMIT     = 500;
  localparam int RUPTURE_RWD = -50;
  localparam int URGENT_TAU  = 200;
  localparam int MAJOR_GAP   = 80;
  localparam int STREAK_STEP = 5;
  localparam int STREAK_MAX  = 50;
  localparam int REWARD_MAX  = 100;
  localparam logic [15:0] INF_RANK = 16'hFFFF;

  localparam logic [15:0] RST_MIN_HOP    = 16'd256;
  localparam logic [15:0] RST_MAX_ETX    = 16'd1024;
  localparam logic [9:0]  RST_HYST       = 10'd75;
  localparam logic [15:0] RST_PC_MARGIN  = 16'd96;
  localparam logic [9:0]  RST_OVR_MARGIN = 10'd20;
  localparam logic [15:0] RST_TRUST      = 16'd8;
  localparam logic [9:0]  RST_PANIC_LVL  = 10'd200;

  typedef enum logic [2:0] {
    REG_MIN_HOP    = 3'd0,
    REG_MAX_ETX    = 3'd1,
    REG_HYST       = 3'd2,
    REG_PC_MARGIN  = 3'd3,
    REG_OVR_MARGIN = 3'd4,
    REG_TRUST      = 3'd5,
    REG_PANIC_LVL  = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    SRC_DIRECT    = 3'd0,
    SRC_FILTER    = 3'd1,
    SRC_BOOTSTRAP = 3'd2,
    SRC_UNCERTAIN = 3'd3,
    SRC_SWITCH    = 3'd4,
    SRC_STAY      = 3'd5
  } src_t;

  typedef enum logic [1:0] {
    ST_URGENT = 2'd0,
    ST_MINOR  = 2'd1,
    ST_MAJOR  = 2'd2
  } qstate_t;

  typedef struct packed {
    logic [15:0] min_hop;
    logic [15:0] max_etx;
    logic [9:0]  hyst;
    logic [15:0] pc_margin;
    logic [9:0]  ovr_margin;
    logic [15:0] trust;
    logic [9:0]  panic_lvl;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/qlps_regs.sv */
// ----------------------------------------------------------------------------
// qlps_regs
// APB-style configuration register file of the parent selector.
// ----------------------------------------------------------------------------
`default_nettype none

module qlps_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output qlps_pkg::cfg_t     cfg
);

  qlps_pkg::cfg_t     cfg_r;
  qlps_pkg::reg_idx_t idx;

  assign idx    = qlps_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_hop    <= qlps_pkg::RST_MIN_HOP;
      cfg_r.max_etx    <= qlps_pkg::RST_MAX_ETX;
      cfg_r.hyst       <= qlps_pkg::RST_HYST;
      cfg_r.pc_margin  <= qlps_pkg::RST_PC_MARGIN;
      cfg_r.ovr_margin <= qlps_pkg::RST_OVR_MARGIN;
      cfg_r.trust      <= qlps_pkg::RST_TRUST;
      cfg_r.panic_lvl  <= qlps_pkg::RST_PANIC_LVL;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        qlps_pkg::REG_MIN_HOP:    cfg_r.min_hop    <= pwdata[15:0];
        qlps_pkg::REG_MAX_ETX:    cfg_r.max_etx    <= pwdata[15:0];
        qlps_pkg::REG_HYST:       cfg_r.hyst       <= pwdata[9:0];
        qlps_pkg::REG_PC_MARGIN:  cfg_r.pc_margin  <= pwdata[15:0];
        qlps_pkg::REG_OVR_MARGIN: cfg_r.ovr_margin <= pwdata[9:0];
        qlps_pkg::REG_TRUST:      cfg_r.trust      <= pwdata[15:0];
        qlps_pkg::REG_PANIC_LVL:  cfg_r.panic_lvl  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      qlps_pkg::REG_MIN_HOP:    prdata = {16'd0, cfg_r.min_hop};
      qlps_pkg::REG_MAX_ETX:    prdata = {16'd0, cfg_r.max_etx};
      qlps_pkg::REG_HYST:       prdata = {22'd0, cfg_r.hyst};
      qlps_pkg::REG_PC_MARGIN:  prdata = {16'd0, cfg_r.pc_margin};
      qlps_pkg::REG_OVR_MARGIN: prdata = {22'd0, cfg_r.ovr_margin};
      qlps_pkg::REG_TRUST:      prdata = {16'd0, cfg_r.trust};
      qlps_pkg::REG_PANIC_LVL:  prdata = {22'd0, cfg_r.panic_lvl};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/qlearning_parent_selector.sv */
// ----------------------------------------------------------------------------
// qlearning_parent_selector
// Two-candidate parent choice with a small Q-learning supervisor.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while out_stall does not hold the
// result register, and returns one result beat for each through the input
// register and the decision and learning logic that writes the result
// register. The Q-table read-modify-write, the streak and the recorded
// state and action are all updated as the result register is written, so
// a beat that follows directly already sees what the previous beat left.
// With the result held by out_stall the input register fills, then in_stall rises.
`default_nettype none

module qlearning_parent_selector (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_op,
  input  wire logic [15:0]       in_rank_a,
  input  wire logic [15:0]       in_rank_b,
  input  wire logic [15:0]       in_etx_a,
  input  wire logic [15:0]       in_etx_b,
  input  wire logic [15:0]       in_tau_a,
  input  wire logic [15:0]       in_tau_b,
  input  wire logic [1:0]        in_pref_which,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_pick_second,
  output logic [2:0]             out_decision_source,
  output logic                   out_panic,
  output logic signed [7:0]      out_reward,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [4:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  function automatic logic [9:0] cap_tau(input logic [15:0] t);
    return (t > 16'(qlps_pkg::TAU_CAP)) ? 10'(qlps_pkg::TAU_CAP) : t[9:0];
  endfunction

  function automatic logic etx_bad(input logic [15:0] e, input logic [15:0] mx);
    return (e == 16'd0) || (e == 16'hFFFF) || (e > mx);
  endfunction

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  qlps_pkg::cfg_t cfg;

  qlps_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // input register
  logic        s1_valid_r;
  logic        s1_op_r;
  logic [15:0] s1_rank_a_r, s1_rank_b_r, s1_etx_a_r, s1_etx_b_r, s1_tau_a_r, s1_tau_b_r;
  logic [1:0]  s1_pref_r;

  // result register
  logic               out_valid_r;
  logic               out_pick_r, pick_nxt;
  qlps_pkg::src_t     out_src_r, src_nxt;
  logic               out_panic_r, panic_nxt;
  logic signed [7:0]  out_reward_r, reward_nxt;

  // learning state
  logic signed [9:0]  q_r [6];
  qlps_pkg::qstate_t  last_state_r, lstate_nxt;
  logic               last_action_r, lact_nxt;
  logic [15:0]        last_etx_r, letx_nxt;
  logic [5:0]         streak_r, streak_nxt;
  logic [15:0]        ucount_r, ucount_nxt;
  logic               q_we;

  logic adv;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;

  // ---------------- compare path ----------------
  logic [9:0]  t1, t2;
  logic        bad_a, bad_b, ok_a, ok_b;
  logic [15:0] step_a, step_b, cost_a, cost_b, r1, r2, pc1, pc2;
  logic        close, pref_ok, pref_second;

  assign t1     = cap_tau(s1_tau_a_r);
  assign t2     = cap_tau(s1_tau_b_r);
  assign bad_a  = etx_bad(s1_etx_a_r, cfg.max_etx);
  assign bad_b  = etx_bad(s1_etx_b_r, cfg.max_etx);
  assign ok_a   = (s1_tau_a_r != 16'd0) && !bad_a;
  assign ok_b   = (s1_tau_b_r != 16'd0) && !bad_b;
  assign step_a = sat_add16(s1_rank_a_r, cfg.min_hop);
  assign step_b = sat_add16(s1_rank_b_r, cfg.min_hop);
  assign cost_a = s1_rank_a_r + s1_etx_a_r;
  assign cost_b = s1_rank_b_r + s1_etx_b_r;
  assign r1     = (step_a > cost_a) ? step_a : cost_a;
  assign r2     = (step_b > cost_b) ? step_b : cost_b;
  assign pc1    = sat_add16(s1_rank_a_r, s1_etx_a_r);
  assign pc2    = sat_add16(s1_rank_b_r, s1_etx_b_r);
  assign close  = ({1'b0, pc1} <= {1'b0, pc2} + {1'b0, cfg.pc_margin}) &&
                  ({1'b0, pc2} <= {1'b0, pc1} + {1'b0, cfg.pc_margin});
  assign pref_ok     = (s1_pref_r == 2'd1) || (s1_pref_r == 2'd2);
  assign pref_second = (s1_pref_r == 2'd2);

  // preferred parent view
  logic [9:0]  tp, tc;
  logic [15:0] pp, pcc, ep, ec;
  logic        sw_base, sw;
  qlps_pkg::qstate_t st;
  logic signed [9:0]  qs, qw;
  logic signed [11:0] om_e;
  logic        boot;

  assign tp  = pref_second ? t2 : t1;
  assign tc  = pref_second ? t1 : t2;
  assign pp  = pref_second ? pc2 : pc1;
  assign pcc = pref_second ? pc1 : pc2;
  assign ep  = pref_second ? s1_etx_b_r : s1_etx_a_r;
  assign ec  = pref_second ? s1_etx_a_r : s1_etx_b_r;
  assign sw_base = (close || (pp <= pcc)) ? !({1'b0, tc} <= {1'b0, tp} + {1'b0, cfg.hyst})
                                          : ({1'b0, tp} <= {1'b0, tc} + {1'b0, cfg.hyst});
  assign st = (tp < 10'(qlps_pkg::URGENT_TAU)) ? qlps_pkg::ST_URGENT :
              ({1'b0, tc} > {1'b0, tp} + 11'(qlps_pkg::MAJOR_GAP)) ? qlps_pkg::ST_MAJOR :
              qlps_pkg::ST_MINOR;
  assign qs   = q_r[{st, 1'b0}];
  assign qw   = q_r[{st, 1'b1}];
  assign om_e = signed'({2'b00, cfg.ovr_margin});
  assign boot = ucount_r < cfg.trust;

  // no preferred parent
  logic tie_pick, direct_pick;
  assign tie_pick = (pc2 < pc1) ? 1'b1 : (pc1 < pc2) ? 1'b0 :
                    (r2 < r1) ? 1'b1 : (r1 < r2) ? 1'b0 : (s1_etx_b_r < s1_etx_a_r);
  assign direct_pick =
    close ? ((t2 > t1) ? 1'b1 : (t1 > t2) ? 1'b0 : tie_pick) :
    (pc1 < pc2) ? ({1'b0, t2} > {1'b0, t1} + {1'b0, cfg.hyst}) :
                  !({1'b0, t1} > {1'b0, t2} + {1'b0, cfg.hyst});

  // ---------------- tick path ----------------
  logic signed [16:0] ediff, ediff_adj;
  logic signed [12:0] d16;
  logic               use_delta;
  logic [5:0]         streak_inc;
  logic signed [13:0] rsum;
  logic signed [7:0]  reward8;
  qlps_pkg::qstate_t  ns;
  logic signed [9:0]  qa, qb, maxn;
  logic signed [12:0] mx, m7, m7_adj;
  logic signed [9:0]  t78;
  logic signed [10:0] target;
  logic signed [9:0]  q_old, q_new;
  logic signed [11:0] qdiff;
  logic signed [8:0]  qstep;
  logic signed [10:0] qsum;
  logic [2:0]         q_idx;

  assign ediff      = signed'({1'b0, last_etx_r}) - signed'({1'b0, s1_etx_a_r});
  assign ediff_adj  = ediff + ((ediff < 0) ? 17'sd15 : 17'sd0);
  assign d16        = ediff_adj[16:4];
  assign use_delta  = (last_etx_r != 16'd0) && (last_etx_r != 16'hFFFF);
  assign streak_inc = (streak_r + 6'(qlps_pkg::STREAK_STEP) > 6'(qlps_pkg::STREAK_MAX)) ?
                      6'(qlps_pkg::STREAK_MAX) : streak_r + 6'(qlps_pkg::STREAK_STEP);
  assign rsum = (use_delta ? 14'(d16) : 14'sd0) +
                (last_action_r ? 14'sd0 : signed'({8'd0, streak_inc}));

  always_comb begin
    if (!pref_ok || bad_a) begin
      reward8 = 8'(qlps_pkg::RUPTURE_RWD);
    end else if (rsum > 14'(qlps_pkg::REWARD_MAX)) begin
      reward8 = 8'(qlps_pkg::REWARD_MAX);
    end else if (rsum < -14'(qlps_pkg::REWARD_MAX)) begin
      reward8 = -8'(qlps_pkg::REWARD_MAX);
    end else begin
      reward8 = rsum[7:0];
    end
  end

  assign ns     = (s1_tau_a_r < 16'(qlps_pkg::URGENT_TAU)) ? qlps_pkg::ST_URGENT
                                                            : qlps_pkg::ST_MINOR;
  assign qa     = q_r[{ns, 1'b0}];
  assign qb     = q_r[{ns, 1'b1}];
  assign maxn   = (qa > qb) ? qa : qb;
  assign mx     = 13'(maxn);
  assign m7     = (mx <<< 3) - mx;
  assign m7_adj = m7 + ((m7 < 0) ? 13'sd7 : 13'sd0);
  assign t78    = m7_adj[12:3];
  assign target = pref_ok ? (11'(reward8) + 11'(t78)) : 11'(qlps_pkg::RUPTURE_RWD);

  assign q_idx = {last_state_r, last_action_r};
  assign q_old = q_r[q_idx];
  assign qdiff = 12'(target) - 12'(q_old);
  assign qstep = qdiff[11:3];
  assign qsum  = 11'(q_old) + 11'(qstep);
  assign q_new = (qsum > 11'(qlps_pkg::Q_LIMIT))  ? 10'(qlps_pkg::Q_LIMIT) :
                 (qsum < -11'(qlps_pkg::Q_LIMIT)) ? -10'(qlps_pkg::Q_LIMIT) : qsum[9:0];

  // ---------------- decision ----------------
  always_comb begin
    pick_nxt   = 1'b0;
    src_nxt    = qlps_pkg::SRC_FILTER;
    panic_nxt  = 1'b0;
    reward_nxt = 8'sd0;
    lstate_nxt = last_state_r;
    lact_nxt   = last_action_r;
    letx_nxt   = last_etx_r;
    streak_nxt = streak_r;
    ucount_nxt = ucount_r;
    q_we       = 1'b0;
    sw         = sw_base;
    if (!s1_op_r) begin
      if (!ok_a) begin
        pick_nxt = 1'b1;
      end else if (!ok_b) begin
        pick_nxt = 1'b0;
      end else if (r1 == qlps_pkg::INF_RANK) begin
        pick_nxt = (r2 != qlps_pkg::INF_RANK);
      end else if (r2 == qlps_pkg::INF_RANK) begin
        pick_nxt = 1'b0;
      end else if (pref_ok) begin
        if (boot) begin
          src_nxt = qlps_pkg::SRC_BOOTSTRAP;
        end else if (!sw_base && (12'(qw) > 12'(qs) + om_e)) begin
          src_nxt = qlps_pkg::SRC_SWITCH;
          sw      = 1'b1;
        end else if (sw_base && (12'(qs) > 12'(qw) + om_e)) begin
          src_nxt = qlps_pkg::SRC_STAY;
          sw      = 1'b0;
        end else begin
          src_nxt = qlps_pkg::SRC_UNCERTAIN;
        end
        lstate_nxt = st;
        lact_nxt   = sw;
        letx_nxt   = sw ? ec : ep;
        pick_nxt   = sw ^ pref_second;
      end else begin
        src_nxt  = qlps_pkg::SRC_DIRECT;
        pick_nxt = direct_pick;
      end
    end else begin
      src_nxt    = qlps_pkg::SRC_DIRECT;
      panic_nxt  = pref_ok && (s1_tau_a_r < {6'd0, cfg.panic_lvl});
      reward_nxt = reward8;
      q_we       = 1'b1;
      if (ucount_r != 16'hFFFF) begin
        ucount_nxt = ucount_r + 16'd1;
      end
      streak_nxt = (!pref_ok || bad_a || last_action_r) ? 6'd0 : streak_inc;
      if (pref_ok) begin
        lstate_nxt = ns;
        letx_nxt   = s1_etx_a_r;
      end
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      last_state_r  <= qlps_pkg::ST_URGENT;
      last_action_r <= 1'b0;
      last_etx_r    <= 16'd0;
      streak_r      <= 6'd0;
      ucount_r      <= 16'd0;
      for (int i = 0; i < 6; i++) begin
        q_r[i] <= 10'sd0;
      end
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (adv && s1_valid_r) begin
        last_state_r  <= lstate_nxt;
        last_action_r <= lact_nxt;
        last_etx_r    <= letx_nxt;
        streak_r      <= streak_nxt;
        ucount_r      <= ucount_nxt;
        if (q_we) begin
          q_r[q_idx] <= q_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r     <= in_op;
      s1_rank_a_r <= in_rank_a;
      s1_rank_b_r <= in_rank_b;
      s1_etx_a_r  <= in_etx_a;
      s1_etx_b_r  <= in_etx_b;
      s1_tau_a_r  <= in_tau_a;
      s1_tau_b_r  <= in_tau_b;
      s1_pref_r   <= in_pref_which;
    end
    if (adv && s1_valid_r) begin
      out_pick_r   <= pick_nxt;
      out_src_r    <= src_nxt;
      out_panic_r  <= panic_nxt;
      out_reward_r <= reward_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pick_second     = out_pick_r;
  assign out_decision_source = out_src_r;
  assign out_panic           = out_panic_r;
  assign out_reward          = out_reward_r;

  // ---------------- assertions ----------------
  a_tick_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_panic_r || (out_reward_r != 8'sd0)) |->
      !out_pick_r && (out_src_r == qlps_pkg::SRC_DIRECT))
    else $error("tick beat carries compare fields");

  a_count_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (ucount_r >= $past(ucount_r)))
    else $error("update count went down");

  a_streak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    streak_r <= 6'(qlps_pkg::STREAK_MAX))
    else $error("stability streak above limit");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with free pipeline");

endmodule

`default_nettype wire

/* tb/tb_qlearning_parent_selector.sv */
// ----------------------------------------------------------------------------
// tb_qlearning_parent_selector
// Self-checking bench for the Q-learning parent selector. Compare and tick
// beats go in on a valid/stall channel with random bursts of idling on both
// sides. An in-bench model of the filter, the hysteresis decision, the
// supervisor override and the Bellman update predicts every result beat,
// which is checked field by field in order. The first phase runs at reset
// values, later ones after APB reprogramming: both extremes, random sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_qlearning_parent_selector;
  import qlps_pkg::*;

  localparam bit OP_COMPARE = 1'b0;
  localparam bit OP_TICK    = 1'b1;
  localparam logic [1:0] PREF_NONE   = 2'd0;
  localparam logic [1:0] PREF_FIRST  = 2'd1;
  localparam logic [1:0] PREF_SECOND = 2'd2;
  localparam logic [1:0] PREF_BAD    = 2'd3;
  localparam int REG_BITS [0:6] = '{16, 16, 10, 16, 10, 16, 10};
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    bit        op;
    bit [15:0] rank_a;
    bit [15:0] rank_b;
    bit [15:0] etx_a;
    bit [15:0] etx_b;
    bit [15:0] tau_a;
    bit [15:0] tau_b;
    bit [1:0]  pref_which;
  } sel_req_t;

  typedef struct {
    bit               pick_second;
    src_t             src;
    bit               panic;
    logic signed [7:0] reward;
  } sel_outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [15:0] in_rank_a = '0;
  logic [15:0] in_rank_b = '0;
  logic [15:0] in_etx_a = '0;
  logic [15:0] in_etx_b = '0;
  logic [15:0] in_tau_a = '0;
  logic [15:0] in_tau_b = '0;
  logic [1:0]  in_pref_which = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_pick_second;
  logic [2:0]  out_decision_source;
  logic        out_panic;
  logic signed [7:0] out_reward;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  qlearning_parent_selector DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_rank_a           (in_rank_a),
    .in_rank_b           (in_rank_b),
    .in_etx_a            (in_etx_a),
    .in_etx_b            (in_etx_b),
    .in_tau_a            (in_tau_a),
    .in_tau_b            (in_tau_b),
    .in_pref_which       (in_pref_which),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pick_second     (out_pick_second),
    .out_decision_source (out_decision_source),
    .out_panic           (out_panic),
    .out_reward          (out_reward),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  always #1 clk = ~clk;

  // selector model state
  int cfg_reg [0:6];
  int qv [0:3][0:1];
  int last_state;
  int last_action;
  int last_etx;
  int streak;
  int upd_count;

  sel_req_t     selector_reqs[$];
  sel_outcome_t predicted_outcomes[$];

  bit in_beat_taken = 1'b0;
  bit src_gaps_on = 1'b0;
  bit sink_gaps_on = 1'b0;
  bit hold_req = 1'b0;
  int src_gap = 0;
  int sink_gap = 0;
  int hold_cnt = 0;
  int errors = 0;
  int idle_cycles = 0;
  int n_compare = 0;
  int n_tick = 0;
  int n_boot = 0;
  int n_override = 0;
  int n_uncertain = 0;
  int n_panic = 0;

  function automatic int cap_tau(input int t);
    return (t > TAU_CAP) ? TAU_CAP : t;
  endfunction

  function automatic bit etx_bad(input int e);
    return (e == 0) || (e == 'hFFFF) || (e > cfg_reg[REG_MAX_ETX]);
  endfunction

  function automatic int rank_through(input int rank, input int etx);
    int step, cost;
    if (etx_bad(etx)) return INF_RANK;
    step = rank + cfg_reg[REG_MIN_HOP];
    if (step > 'hFFFF) step = 'hFFFF;
    cost = (rank + etx) & 'hFFFF;
    return (step > cost) ? step : cost;
  endfunction

  function automatic void learn_q(input int target);
    int v;
    v = qv[last_state][last_action];
    v = v + ((target - v) >>> 3);
    if (v > Q_LIMIT) v = Q_LIMIT;
    if (v < -Q_LIMIT) v = -Q_LIMIT;
    qv[last_state][last_action] = v;
  endfunction

  function automatic sel_outcome_t predict_selection(input sel_req_t it);
    sel_outcome_t r;
    int ra, rb, ea, eb, ta, tb, raw_tau, r1, r2, pc1, pc2, hy, m;
    int tp, tc, pp, pcc, ep, ec, st, ns, qs, qw, rwd, maxn;
    bit pref_ok, pref_second, sw, near;
    r.pick_second = 1'b0;
    r.src = SRC_FILTER;
    r.panic = 1'b0;
    r.reward = '0;
    ra = it.rank_a; rb = it.rank_b;
    ea = it.etx_a; eb = it.etx_b;
    raw_tau = it.tau_a;
    ta = cap_tau(it.tau_a); tb = cap_tau(it.tau_b);
    hy = cfg_reg[REG_HYST];
    m = cfg_reg[REG_PC_MARGIN];
    pref_ok = (it.pref_which == PREF_FIRST) || (it.pref_which == PREF_SECOND);
    if (it.op == OP_TICK) begin
      r.src = SRC_DIRECT;
      if (!pref_ok) begin
        streak = 0;
        if (upd_count < 'hFFFF) upd_count++;
        learn_q(RUPTURE_RWD);
        rwd = RUPTURE_RWD;
      end else begin
        r.panic = raw_tau < cfg_reg[REG_PANIC_LVL];
        rwd = 0;
        if (etx_bad(ea)) begin
          rwd = RUPTURE_RWD;
          streak = 0;
        end else begin
          if (last_etx > 0 && last_etx != 'hFFFF) rwd += (last_etx - ea) / 16;
          if (last_action == 0) begin
            streak += STREAK_STEP;
            if (streak > STREAK_MAX) streak = STREAK_MAX;
            rwd += streak;
          end else begin
            streak = 0;
          end
        end
        if (rwd > REWARD_MAX) rwd = REWARD_MAX;
        if (rwd < -REWARD_MAX) rwd = -REWARD_MAX;
        ns = (ta < URGENT_TAU) ? ST_URGENT : ST_MINOR;
        maxn = (qv[ns][0] > qv[ns][1]) ? qv[ns][0] : qv[ns][1];
        learn_q(rwd + (7 * maxn) / 8);
        last_state = ns;
        last_etx = ea;
        if (upd_count < 'hFFFF) upd_count++;
      end
      r.reward = rwd;
    end else if (ta < 1 || etx_bad(ea)) begin
      r.pick_second = 1'b1;
    end else if (tb < 1 || etx_bad(eb)) begin
      r.pick_second = 1'b0;
    end else begin
      r1 = rank_through(ra, ea);
      r2 = rank_through(rb, eb);
      if (r1 == INF_RANK) begin
        r.pick_second = (r2 != INF_RANK);
      end else if (r2 == INF_RANK) begin
        r.pick_second = 1'b0;
      end else begin
        pc1 = ra + ea; if (pc1 > 'hFFFF) pc1 = 'hFFFF;
        pc2 = rb + eb; if (pc2 > 'hFFFF) pc2 = 'hFFFF;
        if (pref_ok) begin
          pref_second = (it.pref_which == PREF_SECOND);
          tp = pref_second ? tb : ta;   tc = pref_second ? ta : tb;
          pp = pref_second ? pc2 : pc1; pcc = pref_second ? pc1 : pc2;
          ep = pref_second ? eb : ea;   ec = pref_second ? ea : eb;
          near = (pp <= pcc + m) && (pcc <= pp + m);
          if (near || pp <= pcc) sw = !(tc <= tp + hy);
          else sw = (tp <= tc + hy);
          if (tp < URGENT_TAU) st = ST_URGENT;
          else if (tc - tp > MAJOR_GAP) st = ST_MAJOR;
          else st = ST_MINOR;
          if (upd_count < cfg_reg[REG_TRUST]) begin
            r.src = SRC_BOOTSTRAP;
          end else begin
            qs = qv[st][0];
            qw = qv[st][1];
            if (!sw && qw > qs + cfg_reg[REG_OVR_MARGIN]) begin
              r.src = SRC_SWITCH;
              sw = 1'b1;
            end else if (sw && qs > qw + cfg_reg[REG_OVR_MARGIN]) begin
              r.src = SRC_STAY;
              sw = 1'b0;
            end else begin
              r.src = SRC_UNCERTAIN;
            end
          end
          last_state = st;
          last_action = sw;
          last_etx = sw ? ec : ep;
          r.pick_second = (sw != pref_second);
        end else begin
          r.src = SRC_DIRECT;
          near = (pc1 <= pc2 + m) && (pc2 <= pc1 + m);
          if (near && tb != ta) r.pick_second = tb > ta;
          else if (near) begin
            if (pc2 != pc1) r.pick_second = pc2 < pc1;
            else if (r2 != r1) r.pick_second = r2 < r1;
            else r.pick_second = eb < ea;
          end
          else if (pc1 < pc2) r.pick_second = tb > ta + hy;
          else r.pick_second = !(ta > tb + hy);
        end
      end
    end
    return r;
  endfunction

  function automatic sel_req_t mk(input bit op, input int ra, input int rb, input int ea,
                                  input int eb, input int ta, input int tb,
                                  input logic [1:0] pw);
    sel_req_t it;
    it.op = op;
    it.rank_a = ra; it.rank_b = rb;
    it.etx_a = ea; it.etx_b = eb;
    it.tau_a = ta; it.tau_b = tb;
    it.pref_which = pw;
    return it;
  endfunction

  function automatic bit [15:0] pick_rank();
    case ($urandom_range(0, 15))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return $urandom;
      3: return $urandom_range(16'hFF00, 16'hFFFE);
      default: return $urandom_range(0, 3000);
    endcase
  endfunction

  function automatic bit [15:0] pick_etx();
    int emax;
    emax = cfg_reg[REG_MAX_ETX];
    case ($urandom_range(0, 15))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return emax;
      3: return emax + 1;
      4: return $urandom;
      default: return $urandom_range(1, (emax > 3000) ? 3000 : emax);
    endcase
  endfunction

  function automatic bit [15:0] pick_tau();
    case ($urandom_range(0, 15))
      0: return 16'd0;
      1: return $urandom;
      2: return 16'd1000;
      3: return 16'd1001;
      default: return $urandom_range(0, 1050);
    endcase
  endfunction

  function automatic sel_req_t gen_req();
    sel_req_t it;
    int k;
    it.op = ($urandom_range(0, 9) < 3) ? OP_TICK : OP_COMPARE;
    it.rank_a = pick_rank(); it.rank_b = pick_rank();
    it.etx_a = pick_etx();   it.etx_b = pick_etx();
    it.tau_a = pick_tau();   it.tau_b = pick_tau();
    k = $urandom_range(0, 19);
    if (k < 8) it.pref_which = PREF_FIRST;
    else if (k < 16) it.pref_which = PREF_SECOND;
    else if (k < 18) it.pref_which = PREF_NONE;
    else it.pref_which = PREF_BAD;
    return it;
  endfunction

  // input driver
  always @(negedge clk) begin
    sel_req_t it;
    if (!in_valid || in_beat_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (selector_reqs.size() > 0) begin
        it = selector_reqs.pop_front();
        in_op <= it.op;
        in_rank_a <= it.rank_a;
        in_rank_b <= it.rank_b;
        in_etx_a <= it.etx_a;
        in_etx_b <= it.etx_b;
        in_tau_a <= it.tau_a;
        in_tau_b <= it.tau_b;
        in_pref_which <= it.pref_which;
        in_valid <= 1'b1;
        if (src_gaps_on && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver stall
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = $urandom_range(150, 250);
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_stall <= 1'b1;
    end else if (sink_gaps_on && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(1, 15) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check result beats, predict on accepted input beats
  always @(posedge clk) begin
    sel_outcome_t due;
    in_beat_taken = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_outcomes.size() == 0) begin
        $display("%0t: result beat with no prediction pending", $time);
        errors++;
      end else begin
        due = predicted_outcomes.pop_front();
        if (out_pick_second !== due.pick_second) begin
          $display("%0t: pick_second expected %0d actual %0d",
                   $time, due.pick_second, out_pick_second);
          errors++;
        end
        if (out_decision_source !== due.src) begin
          $display("%0t: decision_source expected %0d actual %0d",
                   $time, due.src, out_decision_source);
          errors++;
        end
        if (out_panic !== due.panic) begin
          $display("%0t: panic expected %0d actual %0d", $time, due.panic, out_panic);
          errors++;
        end
        if (out_reward !== due.reward) begin
          $display("%0t: reward expected %0d actual %0d", $time, due.reward, out_reward);
          errors++;
        end
      end
    end
    if (in_beat_taken) begin
      due = predict_selection(mk(in_op, in_rank_a, in_rank_b, in_etx_a, in_etx_b,
                                 in_tau_a, in_tau_b, in_pref_which));
      predicted_outcomes.push_back(due);
      if (in_op == OP_TICK) n_tick++;
      else n_compare++;
      if (due.src == SRC_BOOTSTRAP) n_boot++;
      if (due.src == SRC_SWITCH || due.src == SRC_STAY) n_override++;
      if (due.src == SRC_UNCERTAIN) n_uncertain++;
      if (due.panic) n_panic++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_reg[idx] = val & ((1 << REG_BITS[idx]) - 1);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic program_regs(input int v_min_hop, input int v_max_etx, input int v_hyst,
                              input int v_pcm, input int v_ovr, input int v_trust,
                              input int v_panic);
    int vals [0:6];
    int junk;
    vals[0] = v_min_hop; vals[1] = v_max_etx; vals[2] = v_hyst; vals[3] = v_pcm;
    vals[4] = v_ovr; vals[5] = v_trust; vals[6] = v_panic;
    for (int i = 0; i < 7; i++) begin
      // stray upper bits must be dropped by the register
      junk = ($urandom_range(0, 3) == 0) ? ($urandom << REG_BITS[i]) : 0;
      write_reg(reg_idx_t'(i), vals[i] | junk);
    end
  endtask

  task automatic queue_random(input int n);
    @(posedge clk);
    repeat (n) selector_reqs.push_back(gen_req());
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (selector_reqs.size() != 0 || in_valid);
    @(negedge clk);
    while (predicted_outcomes.size() != 0) @(negedge clk);
  endtask

  initial begin
    cfg_reg[REG_MIN_HOP]    = RST_MIN_HOP;
    cfg_reg[REG_MAX_ETX]    = RST_MAX_ETX;
    cfg_reg[REG_HYST]       = RST_HYST;
    cfg_reg[REG_PC_MARGIN]  = RST_PC_MARGIN;
    cfg_reg[REG_OVR_MARGIN] = RST_OVR_MARGIN;
    cfg_reg[REG_TRUST]      = RST_TRUST;
    cfg_reg[REG_PANIC_LVL]  = RST_PANIC_LVL;
    for (int s = 0; s < 4; s++) begin
      qv[s][0] = 0;
      qv[s][1] = 0;
    end
    last_state = ST_URGENT;
    last_action = 0;
    last_etx = 0;
    streak = 0;
    upd_count = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    src_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;

    // directed beats at reset register values
    selector_reqs.push_back(mk(OP_COMPARE, 100, 100, 10, 10, 0, 500, PREF_NONE));
    selector_reqs.push_back(mk(OP_COMPARE, 100, 100, 0, 10, 500, 500, PREF_NONE));
    selector_reqs.push_back(mk(OP_COMPARE, 100, 100, 10, 'hFFFF, 500, 500, PREF_NONE));
    selector_reqs.push_back(mk(OP_COMPARE, 100, 100, 1025, 10, 500, 500, PREF_NONE));
    selector_reqs.push_back(mk(OP_COMPARE, 'hFFFF, 100, 10, 10, 500, 500, PREF_NONE));
    selector_reqs.push_back(mk(OP_COMPARE, 'hFFFF, 'hFFFF, 10, 10, 500, 500, PREF_NONE));
    selector_reqs.push_back(mk(OP_COMPARE, 100, 'hFFF0, 10, 10, 500, 500, PREF_NONE));
    selector_reqs.push_back(mk(OP_COMPARE, 100, 120, 10, 10, 400, 600, PREF_NONE));
    selector_reqs.push_back(mk(OP_COMPARE, 100, 100, 20, 10, 500, 500, PREF_NONE));
    selector_reqs.push_back(mk(OP_COMPARE, 200, 200, 10, 10, 500, 500, PREF_NONE));
    selector_reqs.push_back(mk(OP_COMPARE, 100, 900, 10, 10, 300, 600, PREF_NONE));
    selector_reqs.push_back(mk(OP_COMPARE, 900, 100, 10, 10, 600, 560, PREF_NONE));
    selector_reqs.push_back(mk(OP_COMPARE, 100, 100, 1024, 1, 'hFFFF, 'hFFFF, PREF_NONE));
    selector_reqs.push_back(mk(OP_COMPARE, 100, 100, 10, 10, 1, 1000, PREF_FIRST));
    selector_reqs.push_back(mk(OP_COMPARE, 100, 300, 10, 10, 500, 900, PREF_SECOND));
    selector_reqs.push_back(mk(OP_COMPARE, 100, 100, 10, 10, 500, 700, PREF_BAD));
    selector_reqs.push_back(mk(OP_TICK, 0, 0, 500, 0, 500, 0, PREF_NONE));
    selector_reqs.push_back(mk(OP_TICK, 0, 0, 500, 0, 500, 0, PREF_BAD));
    selector_reqs.push_back(mk(OP_TICK, 0, 0, 0, 0, 100, 0, PREF_FIRST));
    selector_reqs.push_back(mk(OP_TICK, 'hFFFF, 'hFFFF, 1000, 'hFFFF, 800, 'hFFFF,
                               PREF_FIRST));
    selector_reqs.push_back(mk(OP_TICK, 0, 0, 10, 0, 'hFFFF, 0, PREF_SECOND));
    selector_reqs.push_back(mk(OP_TICK, 0, 0, 1000, 0, 199, 0, PREF_FIRST));
    selector_reqs.push_back(mk(OP_TICK, 0, 0, 1024, 0, 200, 0, PREF_FIRST));
    selector_reqs.push_back(mk(OP_TICK, 0, 0, 1, 0, 0, 0, PREF_SECOND));
    selector_reqs.push_back(mk(OP_COMPARE, 100, 100, 10, 10, 300, 700, PREF_FIRST));
    wait_drained();

    // low extremes
    program_regs(0, 1, 0, 0, 0, 0, 0);
    queue_random(72);
    wait_drained();

    // high extremes
    program_regs(65535, 65534, 1000, 65535, 1000, 65535, 1000);
    queue_random(72);
    wait_drained();

    // random set, receiver holds off long enough to back up the input
    program_regs($urandom_range(0, 1024), $urandom_range(32, 3000), $urandom_range(0, 200),
                 $urandom_range(0, 512), $urandom_range(0, 60), $urandom_range(0, 16),
                 $urandom_range(0, 1000));
    queue_random(72);
    hold_req = 1'b1;
    wait_drained();

    // random set, sender pauses halfway until all results are back
    program_regs($urandom_range(0, 1024), $urandom_range(32, 3000), $urandom_range(0, 200),
                 $urandom_range(0, 512), $urandom_range(0, 60), $urandom_range(0, 16),
                 $urandom_range(0, 1000));
    queue_random(36);
    wait_drained();
    queue_random(36);
    wait_drained();

    program_regs($urandom_range(0, 1024), $urandom_range(32, 3000), $urandom_range(0, 200),
                 $urandom_range(0, 512), $urandom_range(0, 60), $urandom_range(0, 16),
                 $urandom_range(0, 1000));
    queue_random(72);
    wait_drained();

    // back to back, no idling
    program_regs($urandom_range(0, 1024), $urandom_range(32, 3000), $urandom_range(0, 200),
                 $urandom_range(0, 512), $urandom_range(0, 60), $urandom_range(0, 16),
                 $urandom_range(0, 1000));
    @(posedge clk);
    src_gaps_on = 1'b0;
    sink_gaps_on = 1'b0;
    queue_random(72);
    wait_drained();

    repeat (8) @(posedge clk);
    $display("covered %0d compare and %0d tick beats over 7 register settings",
             n_compare, n_tick);
    $display("decisions: %0d bootstrap, %0d override, %0d uncertain; %0d panic ticks",
             n_boot, n_override, n_uncertain, n_panic);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
